>>> rtl/mprt_pkg.sv
// Package for the multilevel priority ready table: words, codes and chain types.
`default_nettype none
package mprt_pkg;

   localparam int PID_W               = 16;
   localparam int SLOTS_PER_LEVEL_DEF = 16;
   localparam int LEVELS_DEF          = 4;

   localparam logic [1:0] CMD_INSERT = 2'd0;
   localparam logic [1:0] CMD_REMOVE = 2'd1;
   localparam logic [1:0] CMD_QUERY  = 2'd2;

   typedef struct packed {
      logic [1:0]       command;
      logic [PID_W-1:0] pid;
      logic [1:0]       priority_req;
   } req_word_type;

   typedef struct packed {
      logic [PID_W-1:0] next_pid;
      logic             next_valid;
      logic             was_full;
   } rsp_word_type;

   // broadcast to every cell
   typedef struct packed {
      logic             en;
      logic [1:0]       command;
      logic [PID_W-1:0] pid;
      logic [1:0]       priority_req;
   } cell_cmd_type;

   // handed from cell to cell, lower index first
   typedef struct packed {
      logic             ins_done;
      logic             found;
      logic [PID_W-1:0] found_pid;
   } chain_type;

endpackage
`default_nettype wire

>>> rtl/mprt_cell.sv
// One slot of the table: pid, valid mark and its link in the priority chain.
`default_nettype none
module mprt_cell #(
   parameter int LEVEL_ID = 0
) (
   input  wire                    clock,
   input  wire                    reset,
   input  mprt_pkg::cell_cmd_type cmd,
   input  mprt_pkg::chain_type    chain_in,
   output mprt_pkg::chain_type    chain_out
);
   import mprt_pkg::*;

   logic [PID_W-1:0] pid_ff;
   logic [PID_W-1:0] pid_in;
   logic             valid_ff;
   logic             valid_in;
   logic             level_hit;
   logic             claim;
   logic             take;

   // levels past what priority_req can name never take an insert
   assign level_hit = (LEVEL_ID < 4) && (cmd.priority_req == 2'(LEVEL_ID));
   assign claim     = (cmd.command == CMD_INSERT) && level_hit && !valid_ff
                      && !chain_in.ins_done;
   assign take      = valid_ff && !chain_in.found;

   assign chain_out.ins_done  = chain_in.ins_done || claim;
   assign chain_out.found     = chain_in.found || valid_ff;
   assign chain_out.found_pid = take ? pid_ff : chain_in.found_pid;

   always_comb begin
      valid_in = valid_ff;
      pid_in   = pid_ff;
      if (cmd.en) begin
         if (claim) begin
            valid_in = 1'b1;
            pid_in   = cmd.pid;
         end else if (cmd.command == CMD_REMOVE && valid_ff && pid_ff == cmd.pid) begin
            valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pid_ff <= pid_in;
   end

endmodule
`default_nettype wire

>>> rtl/multilevel_priority_ready_table_top.sv
// Top level of the multilevel priority ready table: cell row and result register.
//
//   channel | dir | ports                         | word
//   req     | in  | req_valid, req_stall, req_word | command, pid, priority_req
//   rsp     | out | rsp_valid, rsp_stall, rsp_word | next_pid, next_valid, was_full
//
// Each command is handled whole in its accept cycle: the neighbor chain walks
// the whole cell row combinationally and the result is registered.
// One word per cycle while rsp is not stalled; the result is valid in the cycle after acceptance.
// req_stall is high while a result is held and rsp_stall is high.
// Synchronous reset clears all valid marks; no clearing pass is needed.
`default_nettype none
module multilevel_priority_ready_table_top #(
   parameter int SLOTS_PER_LEVEL = mprt_pkg::SLOTS_PER_LEVEL_DEF,
   parameter int LEVELS          = mprt_pkg::LEVELS_DEF
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   output logic                   req_stall,
   input  mprt_pkg::req_word_type req_word,
   output logic                   rsp_valid,
   input  wire                    rsp_stall,
   output mprt_pkg::rsp_word_type rsp_word
);
   import mprt_pkg::*;

   localparam int TOTAL = LEVELS * SLOTS_PER_LEVEL;

   cell_cmd_type cmd;
   chain_type    chain [TOTAL+1];
   logic         accept;
   logic         level_ok;
   logic         rsp_valid_ff;
   logic         rsp_valid_in;
   rsp_word_type rsp_word_ff;
   rsp_word_type rsp_word_in;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   assign cmd.en           = accept;
   assign cmd.command      = req_word.command;
   assign cmd.pid          = req_word.pid;
   assign cmd.priority_req = req_word.priority_req;

   assign chain[0] = '{ins_done: 1'b0, found: 1'b0, found_pid: '0};

   for (genvar lv = 0; lv < LEVELS; lv++) begin : g_level
      for (genvar sl = 0; sl < SLOTS_PER_LEVEL; sl++) begin : g_slot
         mprt_cell #(
            .LEVEL_ID(lv)
         ) u_cell (
            .clock    (clock),
            .reset    (reset),
            .cmd      (cmd),
            .chain_in (chain[lv*SLOTS_PER_LEVEL+sl]),
            .chain_out(chain[lv*SLOTS_PER_LEVEL+sl+1])
         );
      end
   end

   assign level_ok = int'(req_word.priority_req) < LEVELS;

   always_comb begin
      rsp_word_in = '{next_pid: '0, next_valid: 1'b0, was_full: 1'b0};
      unique case (req_word.command)
         CMD_INSERT: rsp_word_in.was_full = level_ok && !chain[TOTAL].ins_done;
         CMD_QUERY: begin
            rsp_word_in.next_valid = chain[TOTAL].found;
            rsp_word_in.next_pid   = chain[TOTAL].found_pid;
         end
         default: ;
      endcase
   end

   assign rsp_valid_in = accept || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule
`default_nettype wire

>>> rtl/mprt_checker.sv
// Port-level checks for the multilevel priority ready table, bound to the top.
`default_nettype none
module mprt_checker (
   input wire                    clock,
   input wire                    reset,
   input wire                    req_valid,
   input wire                    req_stall,
   input mprt_pkg::req_word_type req_word,
   input wire                    rsp_valid,
   input wire                    rsp_stall,
   input mprt_pkg::rsp_word_type rsp_word
);
   import mprt_pkg::*;

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
      else $error("stalled rsp word changed");

   a_one_result: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> rsp_valid)
      else $error("accepted word gave no result");

   a_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_word.next_valid && rsp_word.was_full))
      else $error("next_valid and was_full both set");

   a_pid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_word.next_valid |-> rsp_word.next_pid == '0)
      else $error("next_pid nonzero without next_valid");

endmodule

bind multilevel_priority_ready_table_top mprt_checker u_mprt_checker (.*);
`default_nettype wire

>>> dv/testbench.sv
// Self-checking testbench for the multilevel priority ready table top level.
`timescale 1ns / 100ps
module testbench;
   import mprt_pkg::*;

   localparam int          LEVELS        = LEVELS_DEF;
   localparam int          SLOTS         = SLOTS_PER_LEVEL_DEF;
   localparam int          TOTAL         = LEVELS * SLOTS;
   localparam logic [1:0]  CMD_UNUSED    = 2'd3;
   localparam int          RANDOM_ITEMS  = 675;
   localparam int          POOL          = 24;
   localparam int          HOLD_AT       = 300;
   localparam int          HOLD_CYCLES   = 250;
   localparam int          IDLE_LIMIT    = 2000;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_word_type req_word = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_word_type rsp_word;

   multilevel_priority_ready_table_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // shadow of the ready table
   logic [PID_W-1:0] held_pid [TOTAL];
   bit               occupied [TOTAL];

   req_word_type stimulus [$];
   rsp_word_type due_words [$];
   int           mismatches = 0;
   int           words_out  = 0;
   int           tx_calm    = 0;
   int           rx_calm    = 0;

   function automatic rsp_word_type ready_table_step(req_word_type w);
      rsp_word_type r;
      int           base;
      bit           placed;
      r = '0;
      case (w.command)
         CMD_INSERT: begin
            if (int'(w.priority_req) < LEVELS) begin
               base   = int'(w.priority_req) * SLOTS;
               placed = 1'b0;
               for (int k = 0; k < SLOTS; k++) begin
                  if (!placed && !occupied[base + k]) begin
                     held_pid[base + k] = w.pid;
                     occupied[base + k] = 1'b1;
                     placed = 1'b1;
                  end
               end
               r.was_full = !placed;
            end
         end
         CMD_REMOVE: begin
            for (int i = 0; i < TOTAL; i++)
               if (occupied[i] && held_pid[i] == w.pid) occupied[i] = 1'b0;
         end
         CMD_QUERY: begin
            for (int i = TOTAL - 1; i >= 0; i--) begin
               if (occupied[i]) begin
                  r.next_pid   = held_pid[i];
                  r.next_valid = 1'b1;
               end
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   // idle cycles before a word; now and then a run of back-to-back words
   function automatic int draw_gap(inout int calm);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 39) == 0) calm = $urandom_range(10, 40);
      return $urandom_range(0, 18);
   endfunction

   function automatic void queue_cmd(logic [1:0] c, logic [PID_W-1:0] p, logic [1:0] l);
      req_word_type w;
      w.command      = c;
      w.pid          = p;
      w.priority_req = l;
      stimulus.push_back(w);
   endfunction

   // driver
   int tx_gap = 0;
   always @(posedge clock) begin
      logic         offering;
      req_word_type word_next;
      word_next = req_word;
      offering  = req_valid;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            due_words.push_back(ready_table_step(req_word));
            offering = 1'b0;
         end
         if (!offering) begin
            if (tx_gap > 0) begin
               tx_gap--;
            end else if (stimulus.size() != 0) begin
               word_next = stimulus.pop_front();
               offering  = 1'b1;
               tx_gap    = draw_gap(tx_calm);
            end
         end
      end
      req_valid <= offering;
      req_word  <= word_next;
   end

   // monitor and receiver stalls
   int rx_wait = 0;
   int rx_hold = 0;
   always @(posedge clock) begin
      rsp_word_type due;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (due_words.size() == 0) begin
               $display("%0t: word with nothing due: %h", $time, rsp_word);
               mismatches++;
            end else begin
               due = due_words.pop_front();
               if (rsp_word.next_pid !== due.next_pid) begin
                  $display("%0t: next_pid expected %h actual %h",
                           $time, due.next_pid, rsp_word.next_pid);
                  mismatches++;
               end
               if (rsp_word.next_valid !== due.next_valid) begin
                  $display("%0t: next_valid expected %b actual %b",
                           $time, due.next_valid, rsp_word.next_valid);
                  mismatches++;
               end
               if (rsp_word.was_full !== due.was_full) begin
                  $display("%0t: was_full expected %b actual %b",
                           $time, due.was_full, rsp_word.was_full);
                  mismatches++;
               end
            end
            words_out++;
            rx_wait = draw_gap(rx_calm);
            // one long hold-off so the block backs up into req_stall
            if (words_out == HOLD_AT) rx_hold = HOLD_CYCLES;
         end else if (rx_hold > 0) begin
            rx_hold--;
         end else if (rx_wait > 0) begin
            rx_wait--;
         end
      end
      rsp_stall <= !reset && (rx_hold > 0 || rx_wait > 0);
   end

   // watchdog
   int idle_cycles = 0;
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      logic [PID_W-1:0] pid_pool [POOL];
      logic [PID_W-1:0] pid;
      logic [1:0]       cmd;
      logic [1:0]       lvl;
      logic [1:0]       favored;
      bit               filling;
      int               phase_len;
      int               roll;
      int               n;
      int               total_words;

      for (int i = 0; i < TOTAL; i++) occupied[i] = 1'b0;
      pid_pool[0] = '0;
      pid_pool[1] = '1;
      for (int i = 2; i < POOL; i++) pid_pool[i] = PID_W'($urandom);

      // directed: empty query, unused code, absent remove, duplicate, full level
      queue_cmd(CMD_QUERY, 16'h0000, 2'd0);
      queue_cmd(CMD_UNUSED, 16'hFFFF, 2'd3);
      queue_cmd(CMD_REMOVE, 16'h1234, 2'd0);
      queue_cmd(CMD_INSERT, 16'h0000, 2'd0);
      queue_cmd(CMD_INSERT, 16'h0000, 2'd0);
      queue_cmd(CMD_QUERY, 16'h0000, 2'd0);
      queue_cmd(CMD_REMOVE, 16'h0000, 2'd0);
      for (int k = 0; k <= SLOTS; k++)
         queue_cmd(CMD_INSERT, 16'hFFFF - PID_W'(k), 2'd3);
      queue_cmd(CMD_QUERY, 16'h0000, 2'd0);

      // random: alternating fill and drain phases, one level favored per phase
      n       = 0;
      filling = 1'b0;
      while (n < RANDOM_ITEMS) begin
         phase_len = $urandom_range(20, 60);
         filling   = !filling;
         favored   = 2'($urandom_range(0, 3));
         for (int j = 0; j < phase_len && n < RANDOM_ITEMS; j++) begin
            roll = $urandom_range(0, 99);
            pid  = ($urandom_range(0, 9) == 0) ? PID_W'($urandom)
                                               : pid_pool[$urandom_range(0, POOL - 1)];
            lvl  = ($urandom_range(0, 9) < 7) ? favored : 2'($urandom_range(0, 3));
            if (roll < 5)                           cmd = CMD_UNUSED;
            else if (roll < 25)                     cmd = CMD_QUERY;
            else if (roll < (filling ? 85 : 45))    cmd = CMD_INSERT;
            else                                    cmd = CMD_REMOVE;
            queue_cmd(cmd, pid, lvl);
            n++;
         end
      end
      total_words = stimulus.size();

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // every word sent must come back and be checked
      while (words_out < total_words)
         @(posedge clock);
      repeat (4) @(posedge clock);

      if (mismatches == 0 && due_words.size() == 0 && words_out == total_words) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
